/* hdl/timestamp_window_match_queue_core_defines.svh */
// Assertion macros shared by the timestamp window match queue RTL.
`ifndef TIMESTAMP_WINDOW_MATCH_QUEUE_CORE_DEFINES_SVH
`define TIMESTAMP_WINDOW_MATCH_QUEUE_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TWMQ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TWMQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/twmq_pkg.sv */
// Package with widths, register codes and shared types of the match queue.
package twmq_pkg;

  localparam int STAMP_BITS     = 48;
  localparam int TOL_BITS       = 24;
  localparam int LIMIT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 1;
  localparam int WIN_BITS       = STAMP_BITS + 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_TOL = 1'b1;

  localparam logic [LIMIT_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;
  localparam logic [TOL_BITS-1:0]   DEFAULT_TOL_RESET = 24'd50000;

  typedef struct packed {
    logic hit;
    logic above;
  } win_class_t;

endpackage

/* hdl/twmq_window.sv */
// Window bound registers and the shared stamp compare unit.
module twmq_window
  import twmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic [STAMP_BITS-1:0] lo_stamp,
  input  logic [STAMP_BITS-1:0] hi_stamp,
  input  logic [TOL_BITS-1:0]   tol,
  input  logic [STAMP_BITS-1:0] stamp,
  output win_class_t            cls
);

  logic signed [WIN_BITS-1:0] lower;
  logic signed [WIN_BITS-1:0] upper;
  logic signed [WIN_BITS-1:0] stamp_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      lower <= $signed(WIN_BITS'(lo_stamp)) - $signed(WIN_BITS'(tol));
      upper <= $signed(WIN_BITS'(hi_stamp)) + $signed(WIN_BITS'(tol));
    end
  end

  assign stamp_ext = $signed(WIN_BITS'(stamp));

  always_comb begin
    cls.hit   = (stamp_ext >= lower) && (stamp_ext <= upper);
    cls.above = stamp_ext > upper;
  end

endmodule

/* hdl/timestamp_window_match_queue_core.sv */
// Top level of the bounded, age-ordered timestamp queue with windowed consume.
// An insert passes from acceptance through the reply state to its single
// result, and both kinds of request wait while the result side stalls. The
// entries sit in a circular memory with one registered read port, and a
// consume walks it twice, with a read state and a classify state per entry on
// each pass: the first pass counts matches and survivors so that every result
// can carry the final occupancy and the last flag, the second emits matches
// oldest first and compacts the survivors in place. No new request is taken
// until the current one has delivered its final result to the output register.
`include "timestamp_window_match_queue_core_defines.svh"

module timestamp_window_match_queue_core
  import twmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16,
  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH),
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TOL_BITS-1:0]       cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      req_type,
  input  logic [STAMP_BITS-1:0]     entry_stamp,
  input  logic [HANDLE_BITS-1:0]    entry_handle,
  input  logic [STAMP_BITS-1:0]     window_start,
  input  logic [STAMP_BITS-1:0]     window_end,
  input  logic                      override_valid,
  input  logic [TOL_BITS-1:0]       override_tolerance,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      match_valid,
  output logic [HANDLE_BITS-1:0]    match_handle,
  output logic [STAMP_BITS-1:0]     match_stamp,
  output logic                      last_result,
  output logic                      dropped_oldest,
  output logic [CNT_BITS-1:0]       occupancy
);

  localparam int LW = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WINDOW = 5'b00010,
    S_READ   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  function automatic logic [PTR_BITS-1:0] wrap_add(input logic [PTR_BITS-1:0] base,
                                                   input logic [CNT_BITS-1:0] off);
    logic [CNT_BITS:0] sum;
    sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(off);
    if (sum >= (CNT_BITS + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_BITS + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_BITS-1:0];
  endfunction

  state_t                  state;
  logic [LIMIT_BITS-1:0]   max_entries;
  logic [TOL_BITS-1:0]     default_tolerance;
  logic [PTR_BITS-1:0]     head;
  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     idx;
  logic [CNT_BITS-1:0]     hits;
  logic [CNT_BITS-1:0]     keep;
  logic [CNT_BITS-1:0]     hit_total;
  logic [CNT_BITS-1:0]     keep_total;
  logic                    pass2;
  logic                    reply_drop;
  logic [CNT_BITS-1:0]     reply_occ;
  logic [STAMP_BITS-1:0]   req_min;
  logic [STAMP_BITS-1:0]   req_max;
  logic [TOL_BITS-1:0]     req_tol;

  logic [STAMP_BITS-1:0]   stamp_mem [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0]  handle_mem [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0]   rd_stamp;
  logic [HANDLE_BITS-1:0]  rd_handle;
  logic                    mem_we;
  logic [PTR_BITS-1:0]     mem_wa;
  logic [STAMP_BITS-1:0]   mem_wstamp;
  logic [HANDLE_BITS-1:0]  mem_whandle;
  logic                    mem_re;
  logic [PTR_BITS-1:0]     mem_ra;

  win_class_t              cls;
  logic                    win_load;
  logic                    accept;
  logic                    accept_insert;
  logic                    out_free;
  logic                    advance;
  logic                    res_load;
  logic [LW-1:0]           limit_w;
  logic                    drop;
  logic [CNT_BITS-1:0]     idx_inc;
  logic [CNT_BITS-1:0]     hits_inc;
  logic [CNT_BITS-1:0]     hits_next;
  logic [CNT_BITS-1:0]     keep_next;

  assign req_stall     = (state != S_IDLE);
  assign accept        = req_valid && !req_stall;
  assign accept_insert = accept && !req_type;
  assign out_free      = !res_valid || !res_stall;
  assign win_load      = (state == S_WINDOW);

  assign idx_inc   = idx + CNT_BITS'(1);
  assign hits_inc  = hits + CNT_BITS'(1);
  assign hits_next = cls.hit ? hits_inc : hits;
  assign keep_next = cls.above ? keep + CNT_BITS'(1) : keep;
  assign advance   = !(pass2 && cls.hit) || out_free;
  assign res_load  = out_free && ((state == S_CHECK && pass2 && cls.hit) ||
                                  (state == S_REPLY));

  always_comb begin
    if (max_entries == '0) begin
      limit_w = LW'(1);
    end else if (LW'(max_entries) > LW'(QUEUE_DEPTH)) begin
      limit_w = LW'(QUEUE_DEPTH);
    end else begin
      limit_w = LW'(max_entries);
    end
  end

  assign drop = (LW'(count) >= limit_w) && (count != '0);

  always_comb begin
    mem_we      = 1'b0;
    mem_wa      = wrap_add(head, count);
    mem_wstamp  = entry_stamp;
    mem_whandle = entry_handle;
    if (accept_insert) begin
      mem_we = 1'b1;
    end else if (state == S_CHECK && pass2 && cls.above) begin
      mem_we      = 1'b1;
      mem_wa      = wrap_add(head, keep);
      mem_wstamp  = rd_stamp;
      mem_whandle = rd_handle;
    end
  end

  assign mem_re = (state == S_READ);
  assign mem_ra = wrap_add(head, idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_wa]  <= mem_wstamp;
      handle_mem[mem_wa] <= mem_whandle;
    end
    if (mem_re) begin
      rd_stamp  <= stamp_mem[mem_ra];
      rd_handle <= handle_mem[mem_ra];
    end
  end

  twmq_window u_window (
    .clk      (clk),
    .load     (win_load),
    .lo_stamp (req_min),
    .hi_stamp (req_max),
    .tol      (req_tol),
    .stamp    (rd_stamp),
    .cls      (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries       <= MAX_ENTRIES_RESET;
      default_tolerance <= DEFAULT_TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ENTRIES: max_entries       <= cfg_data[LIMIT_BITS-1:0];
        REG_DEFAULT_TOL: default_tolerance <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type) begin
      req_min <= (window_start < window_end) ? window_start : window_end;
      req_max <= (window_start < window_end) ? window_end : window_start;
      req_tol <= override_valid ? override_tolerance : default_tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept_insert) begin
            if (drop) begin
              head <= wrap_add(head, CNT_BITS'(1));
            end else begin
              count <= count + CNT_BITS'(1);
            end
            reply_drop <= drop;
            reply_occ  <= drop ? count : count + CNT_BITS'(1);
            state      <= S_REPLY;
          end else if (accept) begin
            state <= S_WINDOW;
          end
        end
        S_WINDOW: begin
          idx   <= '0;
          hits  <= '0;
          keep  <= '0;
          pass2 <= 1'b0;
          if (count == '0) begin
            reply_drop <= 1'b0;
            reply_occ  <= '0;
            state      <= S_REPLY;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!pass2) begin
            if (idx_inc == count) begin
              hit_total  <= hits_next;
              keep_total <= keep_next;
              idx        <= '0;
              hits       <= '0;
              keep       <= '0;
              pass2      <= 1'b1;
            end else begin
              idx  <= idx_inc;
              hits <= hits_next;
              keep <= keep_next;
            end
            state <= S_READ;
          end else if (advance) begin
            if (cls.hit) begin
              match_valid    <= 1'b1;
              match_handle   <= rd_handle;
              match_stamp    <= rd_stamp;
              last_result    <= (hits_inc == hit_total);
              dropped_oldest <= 1'b0;
              occupancy      <= keep_total;
            end
            hits <= hits_next;
            keep <= keep_next;
            if (idx_inc == count) begin
              count <= keep_total;
              if (hit_total == '0) begin
                reply_drop <= 1'b0;
                reply_occ  <= keep_total;
                state      <= S_REPLY;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              idx   <= idx_inc;
              state <= S_READ;
            end
          end
        end
        S_REPLY: begin
          if (out_free) begin
            match_valid    <= 1'b0;
            match_handle   <= '0;
            match_stamp    <= '0;
            last_result    <= 1'b1;
            dropped_oldest <= reply_drop;
            occupancy      <= reply_occ;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TWMQ_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_BITS'(QUEUE_DEPTH),
                    "Entry count exceeds the queue depth.")
  `TWMQ_ASSERT_NEXT(a_insert_reply, accept_insert, state == S_REPLY,
                    "Insert transaction did not move to the reply state.")
  `TWMQ_ASSERT_SAME(a_hits_bound, state == S_CHECK && pass2 && cls.hit,
                    hits < hit_total, "Second pass found more matches than the first.")
  `TWMQ_ASSERT_SAME(a_empty_is_last, res_valid && !match_valid, last_result,
                    "Result without a match is not marked last.")

endmodule

/* sim/tb_timestamp_window_match_queue_core.sv */
// Self-checking testbench for the timestamp window match queue with a mirrored queue model.
module tb_timestamp_window_match_queue_core
  import twmq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  localparam logic [STAMP_BITS-1:0]  STAMP_MAX  = '1;
  localparam logic [TOL_BITS-1:0]    TOL_MAX    = '1;
  localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

  localparam int CHUNKS          = 6;
  localparam int CHUNK_ITEMS     = 55;
  localparam int CHUNK_LIMIT [6] = '{16, 4, 1, 0, 31, 8};
  localparam int CHUNK_TOL [6]   = '{50000, 0, 16777215, 1000, 200000, 50000};
  localparam int CHUNK_INSERT [6] = '{55, 55, 60, 70, 85, 55};

  typedef struct packed {
    logic                   req_type;
    logic [STAMP_BITS-1:0]  entry_stamp;
    logic [HANDLE_BITS-1:0] entry_handle;
    logic [STAMP_BITS-1:0]  window_start;
    logic [STAMP_BITS-1:0]  window_end;
    logic                   override_valid;
    logic [TOL_BITS-1:0]    override_tolerance;
  } request_t;

  typedef struct packed {
    logic                   match_valid;
    logic [HANDLE_BITS-1:0] match_handle;
    logic [STAMP_BITS-1:0]  match_stamp;
    logic                   last_result;
    logic                   dropped_oldest;
    logic [CNT_BITS-1:0]    occupancy;
  } match_result_t;

  class window_queue_mirror;
    logic [STAMP_BITS-1:0]  stamps [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] handles [QUEUE_DEPTH];
    int unsigned            held;
    logic [LIMIT_BITS-1:0]  limit_cfg;
    logic [TOL_BITS-1:0]    tol_cfg;
    match_result_t          due_results [$];
    int unsigned            errors;

    function new();
      held      = 0;
      limit_cfg = MAX_ENTRIES_RESET;
      tol_cfg   = DEFAULT_TOL_RESET;
      errors    = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] index, logic [TOL_BITS-1:0] data);
      if (index == REG_MAX_ENTRIES) begin
        limit_cfg = data[LIMIT_BITS-1:0];
      end else if (index == REG_DEFAULT_TOL) begin
        tol_cfg = data;
      end
    endfunction

    function void apply_request(request_t r);
      int unsigned                cap;
      int unsigned                kept;
      bit                         evicted;
      logic [STAMP_BITS-1:0]      lo_end;
      logic [STAMP_BITS-1:0]      hi_end;
      logic [TOL_BITS-1:0]        tol;
      logic signed [WIN_BITS-1:0] lower;
      logic signed [WIN_BITS-1:0] upper;
      logic signed [WIN_BITS-1:0] s;
      match_result_t              res;
      match_result_t              hit_list [$];
      if (r.req_type == REQ_INSERT) begin
        cap = 32'(limit_cfg);
        if (cap < 1) cap = 1;
        if (cap > QUEUE_DEPTH) cap = QUEUE_DEPTH;
        evicted = 0;
        if (held >= cap && held > 0) begin
          for (int i = 1; i < held; i++) begin
            stamps[i-1]  = stamps[i];
            handles[i-1] = handles[i];
          end
          held--;
          evicted = 1;
        end
        if (held < QUEUE_DEPTH) begin
          stamps[held]  = r.entry_stamp;
          handles[held] = r.entry_handle;
          held++;
        end
        res = '0;
        res.last_result    = 1'b1;
        res.dropped_oldest = evicted;
        res.occupancy      = CNT_BITS'(held);
        due_results.insert(due_results.size(), res);
      end else begin
        tol    = r.override_valid ? r.override_tolerance : tol_cfg;
        lo_end = (r.window_start < r.window_end) ? r.window_start : r.window_end;
        hi_end = (r.window_start < r.window_end) ? r.window_end : r.window_start;
        lower  = {2'b00, lo_end};
        lower  = lower - {{(WIN_BITS-TOL_BITS){1'b0}}, tol};
        upper  = {2'b00, hi_end};
        upper  = upper + {{(WIN_BITS-TOL_BITS){1'b0}}, tol};
        kept   = 0;
        for (int i = 0; i < held; i++) begin
          s = {2'b00, stamps[i]};
          if (s >= lower && s <= upper) begin
            res = '0;
            res.match_valid  = 1'b1;
            res.match_handle = handles[i];
            res.match_stamp  = stamps[i];
            hit_list.insert(hit_list.size(), res);
          end else if (s > upper) begin
            stamps[kept]  = stamps[i];
            handles[kept] = handles[i];
            kept++;
          end
        end
        held = kept;
        if (hit_list.size() == 0) begin
          res = '0;
          res.last_result = 1'b1;
          res.occupancy   = CNT_BITS'(held);
          due_results.insert(due_results.size(), res);
        end else begin
          foreach (hit_list[k]) begin
            res = hit_list[k];
            res.last_result = (k == hit_list.size() - 1);
            res.occupancy   = CNT_BITS'(held);
            due_results.insert(due_results.size(), res);
          end
        end
      end
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(match_result_t got);
      match_result_t want;
      if (due_results.size() == 0) begin
        $error("result with no pending request: handle 0x%0h, stamp 0x%0h",
               got.match_handle, got.match_stamp);
        errors++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      compare_field("match_valid", 64'(want.match_valid), 64'(got.match_valid));
      compare_field("match_handle", 64'(want.match_handle), 64'(got.match_handle));
      compare_field("match_stamp", 64'(want.match_stamp), 64'(got.match_stamp));
      compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
      compare_field("dropped_oldest", 64'(want.dropped_oldest), 64'(got.dropped_oldest));
      compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [TOL_BITS-1:0]       cfg_data = '0;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic                      req_type = 1'b0;
  logic [STAMP_BITS-1:0]     entry_stamp = '0;
  logic [HANDLE_BITS-1:0]    entry_handle = '0;
  logic [STAMP_BITS-1:0]     window_start = '0;
  logic [STAMP_BITS-1:0]     window_end = '0;
  logic                      override_valid = 1'b0;
  logic [TOL_BITS-1:0]       override_tolerance = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic                      match_valid;
  logic [HANDLE_BITS-1:0]    match_handle;
  logic [STAMP_BITS-1:0]     match_stamp;
  logic                      last_result;
  logic                      dropped_oldest;
  logic [CNT_BITS-1:0]       occupancy;

  window_queue_mirror    mirror;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  logic [STAMP_BITS-1:0] now_us = '0;

  timestamp_window_match_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .entry_stamp(entry_stamp),
    .entry_handle(entry_handle),
    .window_start(window_start),
    .window_end(window_end),
    .override_valid(override_valid),
    .override_tolerance(override_tolerance),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .match_valid(match_valid),
    .match_handle(match_handle),
    .match_stamp(match_stamp),
    .last_result(last_result),
    .dropped_oldest(dropped_oldest),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        mirror.check_result({match_valid, match_handle, match_stamp, last_result,
                             dropped_oldest, occupancy});
      end
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [STAMP_BITS-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[STAMP_BITS-1:0];
  endfunction

  function automatic request_t mk_insert(logic [STAMP_BITS-1:0] stamp,
                                         logic [HANDLE_BITS-1:0] handle);
    request_t r;
    r = '0;
    r.req_type     = REQ_INSERT;
    r.entry_stamp  = stamp;
    r.entry_handle = handle;
    return r;
  endfunction

  function automatic request_t mk_consume(logic [STAMP_BITS-1:0] t_start,
                                          logic [STAMP_BITS-1:0] t_end,
                                          logic ov, logic [TOL_BITS-1:0] tol);
    request_t r;
    r = '0;
    r.req_type           = REQ_CONSUME;
    r.window_start       = t_start;
    r.window_end         = t_end;
    r.override_valid     = ov;
    r.override_tolerance = tol;
    return r;
  endfunction

  // Mostly a rising epoch clock with windows around recent epochs; unused fields carry noise.
  function automatic request_t make_random_request(int insert_pct);
    request_t              r;
    int                    pick;
    logic [STAMP_BITS-1:0] tmp;
    r.entry_stamp        = rand_stamp();
    r.entry_handle       = HANDLE_BITS'($urandom);
    r.window_start       = rand_stamp();
    r.window_end         = rand_stamp();
    r.override_valid     = 1'($urandom_range(0, 1));
    r.override_tolerance = TOL_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      now_us = rand_stamp();
    end else if (pick < 4) begin
      now_us = STAMP_MAX - $urandom_range(0, 300000);
    end else if (pick < 5) begin
      now_us = STAMP_BITS'($urandom_range(0, 300000));
    end
    if ($urandom_range(0, 99) < insert_pct) begin
      r.req_type = REQ_INSERT;
      now_us = now_us + $urandom_range(1, 100000);
      if ($urandom_range(0, 19) != 0) r.entry_stamp = now_us;
    end else begin
      r.req_type = REQ_CONSUME;
      if ($urandom_range(0, 9) != 0) begin
        r.window_start = now_us - $urandom_range(0, 500000);
        r.window_end   = r.window_start + $urandom_range(0, 300000);
        if ($urandom_range(0, 1) == 1) begin
          tmp            = r.window_start;
          r.window_start = r.window_end;
          r.window_end   = tmp;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        r.override_tolerance = TOL_BITS'($urandom_range(0, 150000));
      end
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid          <= 1'b1;
    req_type           <= r.req_type;
    entry_stamp        <= r.entry_stamp;
    entry_handle       <= r.entry_handle;
    window_start       <= r.window_start;
    window_end         <= r.window_end;
    override_valid     <= r.override_valid;
    override_tolerance <= r.override_tolerance;
    do @(posedge clk); while (!(req_valid && !req_stall));
    mirror.apply_request(r);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0 || req_stall) @(posedge clk);
  endtask

  task automatic write_config(logic [LIMIT_BITS-1:0] limit, logic [TOL_BITS-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_ENTRIES;
    cfg_data  <= TOL_BITS'(limit);
    @(posedge clk);
    mirror.write_register(REG_MAX_ENTRIES, TOL_BITS'(limit));
    cfg_index <= REG_DEFAULT_TOL;
    cfg_data  <= tol;
    @(posedge clk);
    mirror.write_register(REG_DEFAULT_TOL, tol);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    write_config(3, 100);
    send_request(mk_consume(1000, 2000, 1'b0, 0));
    send_request(mk_insert(0, 0));
    send_request(mk_insert(STAMP_MAX, HANDLE_MAX));
    send_request(mk_insert(5000, 16'h5a5a));
    send_request(mk_insert(6000, 16'ha5a5));
    send_request(mk_consume(6050, 4950, 1'b0, 0));
    send_request(mk_consume(0, 0, 1'b1, TOL_MAX));
    send_request(mk_consume(STAMP_MAX, STAMP_MAX, 1'b1, 0));
    send_request(mk_insert(10, 1));
    send_request(mk_insert(20, 2));
    send_request(mk_insert(30000, 3));
    send_request(mk_consume(25, 25, 1'b1, 5));
    send_request(mk_insert(STAMP_MAX, 4));
    send_request(mk_insert(100, 5));
    // The limit now drops below the number of entries held.
    drain_results();
    write_config(1, 100);
    send_request(mk_insert(7, 6));
    send_request(mk_consume(STAMP_MAX, 0, 1'b0, 0));
    drain_results();
    write_config(0, 100);
    send_request(mk_insert(1, 7));
    send_request(mk_insert(2, 8));
    send_request(mk_consume(2, 2, 1'b1, 0));
  endtask

  initial begin
    mirror = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 35;
    recv_stall_pct = 76;
    run_directed();
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == 2) begin
        send_idle_pct  = 76;
        recv_stall_pct = 35;
      end else if (chunk == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      drain_results();
      write_config(LIMIT_BITS'(CHUNK_LIMIT[chunk]), TOL_BITS'(CHUNK_TOL[chunk]));
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        send_request(make_random_request(CHUNK_INSERT[chunk]));
      end
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
